// File: src/eidp_pkg.sv
`default_nettype none
package eidp_pkg;

  localparam logic [7:0] DESC_TAG       = 8'hFC;
  localparam int         FLAG_START_BIT = 7;
  localparam int         FLAG_LEVEL_BIT = 6;

  // result queue geometry
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);
  localparam int QCW    = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    K_HEADER = 2'd0,
    K_AREA   = 2'd1,
    K_DONE   = 2'd2,
    K_ERROR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ERR_SHORT  = 2'd0,
    ERR_TAG    = 2'd1,
    ERR_LENGTH = 2'd2,
    ERR_TRUNC  = 2'd3
  } err_t;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_LENGTH = 2'd1,
    PH_HEADER = 2'd2,
    PH_AREA   = 2'd3
  } phase_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] svc_id;
    logic        start_flag;
    logic        level_flag;
    logic [7:0]  zone_bytes;
    logic [11:0] zone_code;
    err_t        error_code;
    logic [8:0]  consumed_length;
    logic        last;
  } res_t;

  // up to two results written into the queue per byte
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  localparam res_t RES_ZERO = '{kind: K_HEADER, error_code: ERR_SHORT, default: '0};

endpackage
`default_nettype wire

// File: src/eidp_in_if.sv
`default_nettype none
interface eidp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        first_byte;
  logic [15:0] buffer_size;

  modport source (output valid, output data_byte, output first_byte,
                  output buffer_size, input ready);
  modport sink (input valid, input data_byte, input first_byte,
                input buffer_size, output ready);
endinterface
`default_nettype wire

// File: src/eidp_out_if.sv
`default_nettype none
interface eidp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] svc_id;
  logic        start_flag;
  logic        level_flag;
  logic [7:0]  zone_bytes;
  logic [11:0] zone_code;
  logic [1:0]  error_code;
  logic [8:0]  consumed_length;
  logic        last;

  modport source (output valid, output kind, output svc_id, output start_flag,
                  output level_flag, output zone_bytes, output zone_code,
                  output error_code, output consumed_length, output last,
                  input ready);
  modport sink (input valid, input kind, input svc_id, input start_flag,
                input level_flag, input zone_bytes, input zone_code,
                input error_code, input consumed_length, input last,
                output ready);
endinterface
`default_nettype wire

// File: src/emergency_info_descriptor_parser_top.sv
// Path: an accepted byte is held in the input stage until the result queue has
//   room; it is then parsed and its results are written into the queue.
// Throughput: one byte per cycle while the queue has room; the queue drains one
//   beat per cycle while ready, so a byte with two results takes two output beats.
// Reset: synchronous, active low; parser returns to idle, queue and input stage empty.
`default_nettype none
module emergency_info_descriptor_parser_top
  import eidp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  eidp_in_if.sink     in_if,
  eidp_out_if.source  out_if
);

  logic        inq_valid_r, inq_valid_nxt;
  logic [7:0]  inq_byte_r;
  logic        inq_first_r;
  logic [15:0] inq_bs_r;
  logic        room;
  logic        adv;
  logic        in_fire;
  push_t       push;
  res_t        rd_data;

  // parse the held byte once the queue has room for its results
  assign adv          = inq_valid_r && room;
  assign in_if.ready  = !inq_valid_r || adv;
  assign in_fire      = in_if.valid && in_if.ready;
  assign inq_valid_nxt = in_fire || (inq_valid_r && !adv);

  always_ff @(posedge clk) begin
    if (!rst_n) inq_valid_r <= 1'b0;
    else        inq_valid_r <= inq_valid_nxt;
  end

  // capture the input beat
  always_ff @(posedge clk) begin
    if (in_fire) begin
      inq_byte_r  <= in_if.data_byte;
      inq_first_r <= in_if.first_byte;
      inq_bs_r    <= in_if.buffer_size;
    end
  end

  eidp_step u_step (
    .clk         (clk),
    .rst_n       (rst_n),
    .adv         (adv),
    .data_byte   (inq_byte_r),
    .first_byte  (inq_first_r),
    .buffer_size (inq_bs_r),
    .push        (push)
  );

  eidp_resq u_resq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .room     (room),
    .rd_valid (out_if.valid),
    .rd_data  (rd_data),
    .rd_ready (out_if.ready)
  );

  assign out_if.kind            = rd_data.kind;
  assign out_if.svc_id          = rd_data.svc_id;
  assign out_if.start_flag      = rd_data.start_flag;
  assign out_if.level_flag      = rd_data.level_flag;
  assign out_if.zone_bytes      = rd_data.zone_bytes;
  assign out_if.zone_code       = rd_data.zone_code;
  assign out_if.error_code      = rd_data.error_code;
  assign out_if.consumed_length = rd_data.consumed_length;
  assign out_if.last            = rd_data.last;

endmodule
`default_nettype wire

// File: src/eidp_step.sv
`default_nettype none
module eidp_step
  import eidp_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        adv,
  input  wire logic [7:0]  data_byte,
  input  wire logic        first_byte,
  input  wire logic [15:0] buffer_size,
  output push_t            push
);

  phase_t      phase_r, phase_nxt;
  logic [7:0]  blen_r, blen_nxt;
  logic [7:0]  brem_r, brem_nxt;
  logic [15:0] hbs_r, hbs_nxt;
  logic [1:0]  hidx_r, hidx_nxt;
  logic [15:0] sid_r, sid_nxt;
  logic [1:0]  flg_r, flg_nxt;
  logic [7:0]  hab_r, hab_nxt;
  logic [7:0]  abl_r, abl_nxt;
  logic [7:0]  pend_r, pend_nxt;

  // body byte effect, before the end-of-body check
  phase_t      phase_m;
  logic [1:0]  hidx_m;
  logic [15:0] sid_m;
  logic [1:0]  flg_m;
  logic [7:0]  hab_m;
  logic [7:0]  abl_m;
  logic [7:0]  pend_m;
  logic        hdr_emit;
  logic        area_emit;
  logic [7:0]  done_bytes;
  logic        body_end;
  logic        cut;
  logic        len_over;
  logic        in_body;

  assign in_body    = (phase_r == PH_HEADER) || (phase_r == PH_AREA);
  assign done_bytes = hab_r - abl_r;
  assign body_end   = (brem_r == 8'd1);
  assign len_over   = ({8'd0, data_byte} + 16'd2) > hbs_r;

  // walk one body byte through the entry fields
  always_comb begin
    phase_m   = phase_r;
    hidx_m    = hidx_r;
    sid_m     = sid_r;
    flg_m     = flg_r;
    hab_m     = hab_r;
    abl_m     = abl_r;
    pend_m    = pend_r;
    hdr_emit  = 1'b0;
    area_emit = 1'b0;
    if (phase_r == PH_HEADER) begin
      case (hidx_r)
        2'd0: sid_m = {data_byte, 8'd0};
        2'd1: sid_m = {sid_r[15:8], data_byte};
        2'd2: flg_m = {data_byte[FLAG_START_BIT], data_byte[FLAG_LEVEL_BIT]};
        default: begin
          hab_m    = data_byte;
          abl_m    = data_byte;
          hdr_emit = 1'b1;
        end
      endcase
      if (hidx_r == 2'd3) begin
        hidx_m = 2'd0;
        if (data_byte != 8'd0) phase_m = PH_AREA;
      end else begin
        hidx_m = hidx_r + 2'd1;
      end
    end else if (phase_r == PH_AREA) begin
      if (done_bytes[0]) area_emit = 1'b1;
      else pend_m = data_byte;
      abl_m = abl_r - 8'd1;
      if (abl_r == 8'd1) phase_m = PH_HEADER;
    end
  end

  assign cut = (phase_m == PH_AREA) || (hidx_m != 2'd0);

  // next state
  always_comb begin
    phase_nxt = phase_r;
    blen_nxt  = blen_r;
    brem_nxt  = brem_r;
    hbs_nxt   = hbs_r;
    hidx_nxt  = hidx_r;
    sid_nxt   = sid_r;
    flg_nxt   = flg_r;
    hab_nxt   = hab_r;
    abl_nxt   = abl_r;
    pend_nxt  = pend_r;
    if (first_byte) begin
      hidx_nxt = '0; sid_nxt = '0; flg_nxt = '0;
      hab_nxt  = '0; abl_nxt = '0; pend_nxt = '0;
      blen_nxt = '0; brem_nxt = '0;
      if (buffer_size < 16'd2 || data_byte != DESC_TAG) begin
        phase_nxt = PH_IDLE;
      end else begin
        hbs_nxt   = buffer_size;
        phase_nxt = PH_LENGTH;
      end
    end else if (phase_r == PH_LENGTH) begin
      blen_nxt = data_byte;
      if (len_over || data_byte == 8'd0) begin
        phase_nxt = PH_IDLE;
      end else begin
        brem_nxt  = data_byte;
        hidx_nxt  = '0; sid_nxt = '0; flg_nxt = '0;
        hab_nxt   = '0; abl_nxt = '0; pend_nxt = '0;
        phase_nxt = PH_HEADER;
      end
    end else if (in_body) begin
      brem_nxt = brem_r - 8'd1;
      if (body_end) begin
        phase_nxt = PH_IDLE;
        hidx_nxt  = '0; sid_nxt = '0; flg_nxt = '0;
        hab_nxt   = '0; abl_nxt = '0; pend_nxt = '0;
      end else begin
        phase_nxt = phase_m;
        hidx_nxt  = hidx_m;
        sid_nxt   = sid_m;
        flg_nxt   = flg_m;
        hab_nxt   = hab_m;
        abl_nxt   = abl_m;
        pend_nxt  = pend_m;
      end
    end
  end

  // results of this byte
  always_comb begin
    res_t body_res;
    res_t end_res;
    logic body_v;
    logic end_v;
    body_res = RES_ZERO;
    end_res  = RES_ZERO;
    body_v   = 1'b0;
    end_v    = 1'b0;
    push     = '{cnt: 2'd0, r0: RES_ZERO, r1: RES_ZERO};
    if (first_byte) begin
      if (buffer_size < 16'd2) begin
        end_v = 1'b1; end_res.kind = K_ERROR; end_res.error_code = ERR_SHORT;
      end else if (data_byte != DESC_TAG) begin
        end_v = 1'b1; end_res.kind = K_ERROR; end_res.error_code = ERR_TAG;
      end
    end else if (phase_r == PH_LENGTH) begin
      if (len_over) begin
        end_v = 1'b1; end_res.kind = K_ERROR; end_res.error_code = ERR_LENGTH;
      end else if (data_byte == 8'd0) begin
        end_v = 1'b1; end_res.kind = K_DONE; end_res.consumed_length = 9'd2;
      end
    end else if (in_body) begin
      body_v              = hdr_emit || area_emit;
      body_res.kind       = hdr_emit ? K_HEADER : K_AREA;
      body_res.svc_id     = sid_m;
      body_res.start_flag = flg_m[1];
      body_res.level_flag = flg_m[0];
      body_res.zone_bytes = hab_m;
      body_res.zone_code  = area_emit ? {pend_r, data_byte[7:4]} : 12'd0;
      if (body_end) begin
        end_v = 1'b1;
        if (cut) begin
          end_res.kind       = K_ERROR;
          end_res.error_code = ERR_TRUNC;
        end else begin
          end_res.kind            = K_DONE;
          end_res.consumed_length = {1'b0, blen_r} + 9'd2;
        end
      end
    end
    end_res.last  = 1'b1;
    body_res.last = !end_v;
    if (body_v) begin
      push.r0  = body_res;
      push.r1  = end_res;
      push.cnt = end_v ? 2'd2 : 2'd1;
    end else if (end_v) begin
      push.r0  = end_res;
      push.cnt = 2'd1;
    end
    if (!adv) push.cnt = 2'd0;
  end

  // hold state until a byte is processed
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      blen_r  <= '0;
      brem_r  <= '0;
      hbs_r   <= '0;
      hidx_r  <= '0;
      sid_r   <= '0;
      flg_r   <= '0;
      hab_r   <= '0;
      abl_r   <= '0;
      pend_r  <= '0;
    end else if (adv) begin
      phase_r <= phase_nxt;
      blen_r  <= blen_nxt;
      brem_r  <= brem_nxt;
      hbs_r   <= hbs_nxt;
      hidx_r  <= hidx_nxt;
      sid_r   <= sid_nxt;
      flg_r   <= flg_nxt;
      hab_r   <= hab_nxt;
      abl_r   <= abl_nxt;
      pend_r  <= pend_nxt;
    end
  end

endmodule
`default_nettype wire

// File: src/eidp_resq.sv
`default_nettype none
module eidp_resq
  import eidp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire push_t push,
  output logic       room,
  output logic       rd_valid,
  output res_t       rd_data,
  input  wire logic  rd_ready
);

  res_t           mem [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0] cnt_r, cnt_nxt;
  logic           pop;

  // room for the two results one byte may produce
  assign room     = (cnt_r <= QCW'(QDEPTH - 2));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem[rd_ptr_r];
  assign pop      = rd_valid && rd_ready;

  assign wr_ptr_nxt = wr_ptr_r + QAW'(push.cnt);
  assign rd_ptr_nxt = rd_ptr_r + QAW'(pop);
  assign cnt_nxt    = cnt_r + QCW'(push.cnt) - QCW'(pop);

  // write up to two beats per cycle
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem[wr_ptr_r] <= push.r0;
    if (push.cnt == 2'd2) mem[wr_ptr_r + QAW'(1)] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire
